/* hdl/two_way_traffic_light_controller_unit_macros.svh */
// Assertion macros for the traffic light controller checker.
// Used by files that assert; needs nothing else.
`ifndef TWO_WAY_TRAFFIC_LIGHT_CONTROLLER_UNIT_MACROS_SVH
`define TWO_WAY_TRAFFIC_LIGHT_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("tlc: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("tlc: next-cycle check failed");

`endif

/* hdl/tlc_pkg.sv */
// Shared types and constants for the traffic light controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package tlc_pkg;

  // Lamp bytes
  localparam logic [7:0] LAMP_EW_GREEN  = 8'h7e;
  localparam logic [7:0] LAMP_EW_YELLOW = 8'h7d;
  localparam logic [7:0] LAMP_NS_GREEN  = 8'hdb;
  localparam logic [7:0] LAMP_NS_YELLOW = 8'hbb;
  localparam logic [7:0] LAMP_ALL_RED   = 8'h7b;

  localparam logic [6:0] COUNT_CAP = 7'd99;

  // Register reset values
  localparam logic [3:0] YELLOW_TIME_RST   = 4'd5;
  localparam logic [6:0] GREEN_DEFAULT_RST = 7'd30;
  localparam logic [4:0] GREEN_STEP_RST    = 5'd5;
  localparam logic [6:0] GREEN_MIN_RST     = 7'd10;
  localparam logic [6:0] GREEN_MAX_RST     = 7'd60;

  // State reset values
  localparam logic [6:0] EW_LEFT_RST    = 7'd30;
  localparam logic [6:0] NS_LEFT_RST    = 7'd35;
  localparam logic [6:0] GREEN_TIME_RST = 7'd30;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_YELLOW_TIME   = 3'd0,
    REG_GREEN_DEFAULT = 3'd1,
    REG_GREEN_STEP    = 3'd2,
    REG_GREEN_MIN     = 3'd3,
    REG_GREEN_MAX     = 3'd4
  } reg_idx_e;

  typedef enum logic [3:0] {
    PH_EW_GREEN  = 4'b0001,
    PH_EW_YELLOW = 4'b0010,
    PH_NS_GREEN  = 4'b0100,
    PH_NS_YELLOW = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [3:0] yellow_time;
    logic [6:0] green_default;
    logic [4:0] green_step;
    logic [6:0] green_min;
    logic [6:0] green_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] lamp_pattern;
    logic       lamp_update;
    logic       display_update;
    logic [3:0] ew_units;
    logic [3:0] ew_tens;
    logic [3:0] ns_units;
    logic [3:0] ns_tens;
    logic       emergency_active;
  } res_t;

endpackage

`default_nettype wire

/* hdl/two_way_traffic_light_controller_unit.sv */
// Two-way traffic light controller: input register, sequencer, result register.
// Depends on tlc_pkg, tlc_cfg and tlc_step.
//
// Use:
//   Input channel (in_valid_i/in_ready_o) carries one item: kind_i selects a
//   one-second tick (0) or a key scan sample (1) with key_levels_i.
//   Output channel (out_valid_o/out_ready_i) returns exactly one result per
//   item: lamp byte, update flags, BCD countdown digits and emergency flag.
//   Timing registers sit behind the APB port at byte addresses 0,4,..,16;
//   pready is tied high and writes land on the access cycle.
// Path: an accepted item is held in the input register, and its result is
//   registered in the output register once that register is free.
// Throughput: one item per cycle while results are taken; the update is a
//   single sequencer pass between the input register and the result register.
// Reset: phase east-west green, countdowns 30/35, green time 30, emergency off,
//   timing registers at their defaults, both channels empty.
// Stall: a held result keeps the output register; one more item waits in the
//   input register, then in_ready_o drops until the result is taken.
`default_nettype none

module two_way_traffic_light_controller_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tlc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tlc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tlc_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [3:0]                   key_levels_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [7:0]                   lamp_pattern_o,
  output logic                              lamp_update_o,
  output logic                              display_update_o,
  output logic      [3:0]                   ew_units_o,
  output logic      [3:0]                   ew_tens_o,
  output logic      [3:0]                   ns_units_o,
  output logic      [3:0]                   ns_tens_o,
  output logic                              emergency_active_o
);
  import tlc_pkg::*;

  cfg_t       cfg;
  res_t       res;
  res_t       out_q;
  logic       s1_valid_q, s1_valid_d;
  logic       s1_kind_q;
  logic [3:0] s1_keys_q;
  logic       out_valid_q, out_valid_d;
  logic       step_go;
  logic       in_take;

  tlc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlc_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_en_i    (step_go),
    .kind_i       (s1_kind_q),
    .key_levels_i (s1_keys_q),
    .res_o        (res)
  );

  // advance the held item when the result register is free or being emptied
  assign step_go    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || step_go;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step_go) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_kind_q <= kind_i;
      s1_keys_q <= key_levels_i;
    end
    if (step_go) begin
      out_q <= res;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign lamp_pattern_o     = out_q.lamp_pattern;
  assign lamp_update_o      = out_q.lamp_update;
  assign display_update_o   = out_q.display_update;
  assign ew_units_o         = out_q.ew_units;
  assign ew_tens_o          = out_q.ew_tens;
  assign ns_units_o         = out_q.ns_units;
  assign ns_tens_o          = out_q.ns_tens;
  assign emergency_active_o = out_q.emergency_active;

endmodule

`default_nettype wire

/* hdl/tlc_cfg.sv */
// APB register file for the traffic light timing settings.
// Depends on tlc_pkg.
`default_nettype none

module tlc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tlc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [tlc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tlc_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output tlc_pkg::cfg_t                     cfg_o
);
  import tlc_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_YELLOW_TIME:   cfg_d.yellow_time   = pwdata[3:0];
        REG_GREEN_DEFAULT: cfg_d.green_default = pwdata[6:0];
        REG_GREEN_STEP:    cfg_d.green_step    = pwdata[4:0];
        REG_GREEN_MIN:     cfg_d.green_min     = pwdata[6:0];
        REG_GREEN_MAX:     cfg_d.green_max     = pwdata[6:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_YELLOW_TIME:   prdata = {28'd0, cfg_q.yellow_time};
      REG_GREEN_DEFAULT: prdata = {25'd0, cfg_q.green_default};
      REG_GREEN_STEP:    prdata = {27'd0, cfg_q.green_step};
      REG_GREEN_MIN:     prdata = {25'd0, cfg_q.green_min};
      REG_GREEN_MAX:     prdata = {25'd0, cfg_q.green_max};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.yellow_time   <= YELLOW_TIME_RST;
      cfg_q.green_default <= GREEN_DEFAULT_RST;
      cfg_q.green_step    <= GREEN_STEP_RST;
      cfg_q.green_min     <= GREEN_MIN_RST;
      cfg_q.green_max     <= GREEN_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/tlc_step.sv */
// Sequencer state and the single-pass update for one item.
// Depends on tlc_pkg; driven by the top level's input register.
`default_nettype none

module tlc_step (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tlc_pkg::cfg_t cfg_i,
  input  wire logic          step_en_i,
  input  wire logic          kind_i,
  input  wire logic [3:0]    key_levels_i,
  output tlc_pkg::res_t      res_o
);
  import tlc_pkg::*;

  phase_e     phase_q, phase_d;
  logic [6:0] ew_q, ew_d;
  logic [6:0] ns_q, ns_d;
  logic [6:0] gt_q, gt_d;
  logic       emg_q, emg_d;
  logic [3:0] kb_q, kb_d;

  logic [6:0] ew_dec, ns_dec;
  logic [3:0] released;
  logic       reload, disp;
  logic [7:0] inc_sum, dec_lim, gy_sum;
  logic [6:0] g_cap, gy_cap;

  function automatic logic [7:0] lamp_of(phase_e p, logic emg);
    logic [7:0] l;
    if (emg) begin
      l = LAMP_ALL_RED;
    end else begin
      case (p)
        PH_EW_GREEN:  l = LAMP_EW_GREEN;
        PH_EW_YELLOW: l = LAMP_EW_YELLOW;
        PH_NS_GREEN:  l = LAMP_NS_GREEN;
        PH_NS_YELLOW: l = LAMP_NS_YELLOW;
        default:      l = LAMP_EW_GREEN;
      endcase
    end
    return l;
  endfunction

  function automatic phase_e phase_next(phase_e p);
    phase_e n;
    case (p)
      PH_EW_GREEN:  n = PH_EW_YELLOW;
      PH_EW_YELLOW: n = PH_NS_GREEN;
      PH_NS_GREEN:  n = PH_NS_YELLOW;
      PH_NS_YELLOW: n = PH_EW_GREEN;
      default:      n = PH_EW_GREEN;
    endcase
    return n;
  endfunction

  function automatic logic [6:0] cap99(logic [7:0] v);
    return (v > {1'b0, COUNT_CAP}) ? COUNT_CAP : v[6:0];
  endfunction

  // Tens digit by reciprocal multiply, exact for values up to 99.
  function automatic logic [3:0] tens_of(logic [6:0] v);
    logic [14:0] p;
    p = {8'd0, v} * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(logic [6:0] v, logic [3:0] t);
    logic [6:0] u;
    u = v - ({3'd0, t} * 7'd10);
    return u[3:0];
  endfunction

  assign ew_dec = (ew_q != 7'd0) ? ew_q - 7'd1 : 7'd0;
  assign ns_dec = (ns_q != 7'd0) ? ns_q - 7'd1 : 7'd0;

  always_comb begin
    phase_d  = phase_q;
    ew_d     = ew_q;
    ns_d     = ns_q;
    gt_d     = gt_q;
    emg_d    = emg_q;
    kb_d     = kb_q;
    disp     = 1'b0;
    reload   = 1'b0;
    released = 4'd0;
    inc_sum  = {1'b0, gt_q} + {3'd0, cfg_i.green_step};
    dec_lim  = '0;
    if (!kind_i) begin
      // frozen while in emergency
      if (!emg_q) begin
        ew_d = ew_dec;
        ns_d = ns_dec;
        disp = 1'b1;
        if (ew_dec == 7'd0 || ns_dec == 7'd0) begin
          phase_d = phase_next(phase_q);
          reload  = 1'b1;
        end
      end
    end else begin
      released = kb_q & ~key_levels_i;
      kb_d     = key_levels_i;
      if (released[0]) begin
        gt_d   = (inc_sum > {1'b0, cfg_i.green_max}) ? cfg_i.green_default : inc_sum[6:0];
        reload = 1'b1;
      end
      if (released[1]) begin
        // wrap when the difference would drop below the minimum
        dec_lim = {1'b0, cfg_i.green_min} + {3'd0, cfg_i.green_step};
        gt_d    = ({1'b0, gt_d} < dec_lim) ? cfg_i.green_default
                                           : gt_d - {2'd0, cfg_i.green_step};
        reload  = 1'b1;
      end
      if (released[2]) begin
        emg_d = 1'b1;
      end
      if (released[3]) begin
        emg_d = 1'b0;
        disp  = 1'b1;
      end
    end

    gy_sum = {1'b0, gt_d} + {4'd0, cfg_i.yellow_time};
    g_cap  = cap99({1'b0, gt_d});
    gy_cap = cap99(gy_sum);
    if (reload) begin
      case (phase_d)
        PH_EW_GREEN: begin
          ew_d = g_cap;
          ns_d = gy_cap;
        end
        PH_NS_GREEN: begin
          ew_d = gy_cap;
          ns_d = g_cap;
        end
        default: begin
          ew_d = {3'd0, cfg_i.yellow_time};
          ns_d = {3'd0, cfg_i.yellow_time};
        end
      endcase
    end
  end

  always_comb begin
    res_o.lamp_pattern     = lamp_of(phase_d, emg_d);
    res_o.lamp_update      = lamp_of(phase_d, emg_d) != lamp_of(phase_q, emg_q);
    res_o.display_update   = disp;
    res_o.ew_tens          = tens_of(ew_d);
    res_o.ew_units         = units_of(ew_d, tens_of(ew_d));
    res_o.ns_tens          = tens_of(ns_d);
    res_o.ns_units         = units_of(ns_d, tens_of(ns_d));
    res_o.emergency_active = emg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EW_GREEN;
      ew_q    <= EW_LEFT_RST;
      ns_q    <= NS_LEFT_RST;
      gt_q    <= GREEN_TIME_RST;
      emg_q   <= 1'b0;
      kb_q    <= 4'd0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      ew_q    <= ew_d;
      ns_q    <= ns_d;
      gt_q    <= gt_d;
      emg_q   <= emg_d;
      kb_q    <= kb_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/tlc_checker.sv */
// Port-level checks for the traffic light controller, bound to the top level.
// Depends on tlc_pkg and the assertion macro header.
`default_nettype none
`include "two_way_traffic_light_controller_unit_macros.svh"

module tlc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] lamp_pattern_o,
  input wire logic [3:0] ew_units_o,
  input wire logic [3:0] ew_tens_o,
  input wire logic [3:0] ns_units_o,
  input wire logic [3:0] ns_tens_o,
  input wire logic       emergency_active_o
);
  import tlc_pkg::*;

  `TLC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(lamp_pattern_o) && $stable(ew_units_o) && $stable(ns_units_o))
  `TLC_ASSERT_IMPLY(a_emg_red, clk_i, rst_ni, out_valid_o && emergency_active_o,
    lamp_pattern_o == LAMP_ALL_RED)
  `TLC_ASSERT_IMPLY(a_phase_lamp, clk_i, rst_ni, out_valid_o && !emergency_active_o,
    lamp_pattern_o == LAMP_EW_GREEN || lamp_pattern_o == LAMP_EW_YELLOW ||
    lamp_pattern_o == LAMP_NS_GREEN || lamp_pattern_o == LAMP_NS_YELLOW)
  `TLC_ASSERT_IMPLY(a_bcd_digits, clk_i, rst_ni, out_valid_o,
    ew_units_o <= 4'd9 && ew_tens_o <= 4'd9 && ns_units_o <= 4'd9 && ns_tens_o <= 4'd9)

endmodule

bind two_way_traffic_light_controller_unit tlc_checker u_tlc_checker (.*);

`default_nettype wire
